/* rtl/fba_pkg.sv */
// Shared types and constants for the frame bitmap allocator.
`default_nettype none

package fba_pkg;

  localparam int MAX_FRAMES_DEF = 32768;
  localparam int PAGE_BYTES_DEF = 4096;

  localparam logic [15:0] FRAME_COUNT_RST = 16'd32768;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_MARK  = 2'd2,
    CMD_TEST  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [14:0] frame_out;
    logic        present;
    logic        rw;
    logic        user;
    logic        bit_set;
  } result_t;

endpackage

`default_nettype wire

/* rtl/fba_in_if.sv */
// Command channel of the frame bitmap allocator.
`default_nettype none

interface fba_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] address;
  logic [14:0] page_frame;
  logic        kernel_alloc;
  logic        rw_alloc;

  modport source (output valid, cmd, address, page_frame, kernel_alloc, rw_alloc,
                  input ready);
  modport sink (input valid, cmd, address, page_frame, kernel_alloc, rw_alloc,
                output ready);
endinterface

`default_nettype wire

/* rtl/fba_out_if.sv */
// Result channel of the frame bitmap allocator.
`default_nettype none

interface fba_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [14:0] frame_out;
  logic        present;
  logic        rw;
  logic        user;
  logic        bit_set;

  modport source (output valid, status, frame_out, present, rw, user, bit_set,
                  input ready);
  modport sink (input valid, status, frame_out, present, rw, user, bit_set,
                output ready);
endinterface

`default_nettype wire

/* rtl/fba_cfg_if.sv */
// Configuration write channel carrying the frame count register.
`default_nettype none

interface fba_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_count;

  modport source (output valid, frame_count, input ready);
  modport sink (input valid, frame_count, output ready);
endinterface

`default_nettype wire

/* rtl/fba_bitmap_mem.sv */
// Used/free bitmap storage: one write port and one registered read port.
`default_nettype none

module fba_bitmap_mem #(
  parameter int WORDS = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [31:0]   rdata
);

  logic [31:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/fba_word_unit.sv */
// Shared word unit: lowest free bit under a limit, and single-bit set, clear and test.
`default_nettype none

module fba_word_unit (
  input  wire logic [31:0] word,
  input  wire logic [4:0]  bit_sel,
  input  wire logic        lim_en,
  input  wire logic [4:0]  lim_lo,
  output logic      [31:0] set_word,
  output logic      [31:0] clr_word,
  output logic             bit_val,
  output logic             found,
  output logic      [4:0]  free_bit,
  output logic      [31:0] alloc_word
);

  logic [31:0] avail;
  logic [31:0] sel_mask;

  always_comb begin
    sel_mask = 32'd1 << bit_sel;
    set_word = word | sel_mask;
    clr_word = word & ~sel_mask;
    bit_val  = word[bit_sel];

    // In the word holding the frame count, frames at or above the count are off limits.
    avail = ~word & ~(lim_en ? ({32{1'b1}} << lim_lo) : 32'd0);
    found = |avail;
    free_bit = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (avail[i]) begin
        free_bit = 5'(i);
      end
    end
    alloc_word = word | (32'd1 << free_bit);
  end

endmodule

`default_nettype wire

/* rtl/fba_ctrl.sv */
// Sequencer: clearing sweep, word-by-word allocation scan and read-modify-write of the bitmap.
`default_nettype none

module fba_ctrl #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BYTES = fba_pkg::PAGE_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] frame_count,
  input  wire logic        start,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] address,
  input  wire logic [14:0] page_frame,
  input  wire logic        kernel_alloc,
  input  wire logic        rw_alloc,
  input  wire logic        res_ack,
  output logic             idle,
  output logic             done,
  output fba_pkg::result_t res
);

  localparam int WORDS = (MAX_FRAMES + 31) / 32;
  localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int NW    = $clog2(MAX_FRAMES + 1);
  localparam int PSH   = $clog2(PAGE_BYTES);
  localparam int AFW   = 32 - PSH;
  localparam int CW0   = (NW > AFW) ? NW : AFW;
  localparam int CW    = (CW0 > 16) ? CW0 : 16;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_RMW,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [AW-1:0]    clr_idx_r, clr_idx_nxt;
  logic [AW:0]      rd_idx_r, rd_idx_nxt;
  logic             ev_vld_r, ev_vld_nxt;
  logic [AW-1:0]    ev_idx_r, ev_idx_nxt;
  logic [NW-1:0]    n_r, n_nxt;
  logic [AW:0]      words_r, words_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [AW-1:0]    tgt_word_r, tgt_word_nxt;
  logic [4:0]       tgt_bit_r, tgt_bit_nxt;
  logic             wr_r, wr_nxt;
  logic             kern_r, kern_nxt;
  fba_pkg::result_t res_r, res_nxt;

  logic [CW-1:0]    fc_c, max_c, n_c, pf_c, af_c;
  logic [AW:0]      words_c;
  logic [AW-1:0]    tgt_word_c;
  logic [4:0]       tgt_bit_c;
  logic [AW:0]      n_word;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [31:0]      mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [31:0]      mem_q;

  logic [31:0]      wu_set, wu_clr, wu_alloc;
  logic             wu_bit, wu_found;
  logic [4:0]       wu_free_bit;

  fba_bitmap_mem #(
    .WORDS (WORDS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_q)
  );

  fba_word_unit u_word (
    .word       (mem_q),
    .bit_sel    (tgt_bit_r),
    .lim_en     ({1'b0, ev_idx_r} == n_word),
    .lim_lo     (n_r[4:0]),
    .set_word   (wu_set),
    .clr_word   (wu_clr),
    .bit_val    (wu_bit),
    .found      (wu_found),
    .free_bit   (wu_free_bit),
    .alloc_word (wu_alloc)
  );

  always_comb begin
    fc_c    = CW'(frame_count);
    max_c   = CW'(MAX_FRAMES);
    n_c     = (fc_c > max_c) ? max_c : fc_c;
    pf_c    = CW'(page_frame);
    af_c    = CW'(address >> PSH);
    words_c = (AW+1)'(({1'b0, n_c} + (CW+1)'(31)) >> 5);
    n_word  = (AW+1)'(n_r >> 5);

    if (cmd == fba_pkg::CMD_FREE) begin
      tgt_word_c = AW'(pf_c >> 5);
      tgt_bit_c  = pf_c[4:0];
    end else begin
      tgt_word_c = AW'(af_c >> 5);
      tgt_bit_c  = af_c[4:0];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_idx_nxt  = clr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    ev_vld_nxt   = ev_vld_r;
    ev_idx_nxt   = ev_idx_r;
    n_nxt        = n_r;
    words_nxt    = words_r;
    cmd_nxt      = cmd_r;
    tgt_word_nxt = tgt_word_r;
    tgt_bit_nxt  = tgt_bit_r;
    wr_nxt       = wr_r;
    kern_nxt     = kern_r;
    res_nxt      = res_r;

    mem_we    = 1'b0;
    mem_waddr = tgt_word_r;
    mem_wdata = wu_set;
    mem_raddr = tgt_word_r;

    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = 32'd0;
        if (clr_idx_r == AW'(WORDS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + AW'(1);
        end
      end

      S_IDLE: begin
        mem_raddr = tgt_word_c;
        if (start) begin
          res_nxt      = '0;
          n_nxt        = NW'(n_c);
          words_nxt    = words_c;
          cmd_nxt      = cmd;
          tgt_word_nxt = tgt_word_c;
          tgt_bit_nxt  = tgt_bit_c;
          wr_nxt       = rw_alloc;
          kern_nxt     = kernel_alloc;
          rd_idx_nxt   = '0;
          ev_vld_nxt   = 1'b0;
          case (cmd)
            fba_pkg::CMD_ALLOC: begin
              if (page_frame != 15'd0) begin
                res_nxt.status = fba_pkg::STAT_NONE;
                state_nxt      = S_DONE;
              end else if (n_c == '0) begin
                res_nxt.status = fba_pkg::STAT_FULL;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            fba_pkg::CMD_FREE: begin
              if (page_frame == 15'd0) begin
                res_nxt.status = fba_pkg::STAT_NONE;
                state_nxt      = S_DONE;
              end else if (pf_c >= n_c) begin
                res_nxt.status = fba_pkg::STAT_RANGE;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RMW;
              end
            end
            default: begin
              if (af_c >= n_c) begin
                res_nxt.status = fba_pkg::STAT_RANGE;
                state_nxt      = S_DONE;
              end else begin
                state_nxt = S_RMW;
              end
            end
          endcase
        end
      end

      S_SCAN: begin
        // A read is issued for one word while the previously read word is examined.
        mem_raddr = rd_idx_r[AW-1:0];
        mem_waddr = ev_idx_r;
        mem_wdata = wu_alloc;
        if (ev_vld_r && wu_found) begin
          mem_we            = 1'b1;
          res_nxt.status    = fba_pkg::STAT_DONE;
          res_nxt.frame_out = 15'({ev_idx_r, wu_free_bit});
          res_nxt.present   = 1'b1;
          res_nxt.rw        = wr_r;
          res_nxt.user      = ~kern_r;
          state_nxt         = S_DONE;
        end else if (!ev_vld_r && (rd_idx_r >= words_r)) begin
          res_nxt.status = fba_pkg::STAT_FULL;
          state_nxt      = S_DONE;
        end else if (rd_idx_r < words_r) begin
          ev_vld_nxt = 1'b1;
          ev_idx_nxt = rd_idx_r[AW-1:0];
          rd_idx_nxt = rd_idx_r + (AW+1)'(1);
        end else begin
          ev_vld_nxt = 1'b0;
        end
      end

      S_RMW: begin
        case (cmd_r)
          fba_pkg::CMD_FREE: begin
            mem_we    = 1'b1;
            mem_wdata = wu_clr;
          end
          fba_pkg::CMD_MARK: begin
            mem_we    = 1'b1;
            mem_wdata = wu_set;
          end
          fba_pkg::CMD_TEST: begin
            res_nxt.bit_set = wu_bit;
          end
          default: begin
          end
        endcase
        state_nxt = S_DONE;
      end

      S_DONE: begin
        if (res_ack) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_idx_r <= '0;
      rd_idx_r  <= '0;
      ev_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_idx_r  <= clr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      ev_vld_r   <= ev_vld_nxt;
      ev_idx_r   <= ev_idx_nxt;
      n_r        <= n_nxt;
      words_r    <= words_nxt;
      cmd_r      <= cmd_nxt;
      tgt_word_r <= tgt_word_nxt;
      tgt_bit_r  <= tgt_bit_nxt;
      wr_r       <= wr_nxt;
      kern_r     <= kern_nxt;
      res_r      <= res_nxt;
    end
  end

  assign idle = (state_r == S_IDLE);
  assign done = (state_r == S_DONE);
  assign res  = res_r;

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DONE) |-> !mem_we)
    else $error("bitmap written while no command is in progress");

  a_ack_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    res_ack |=> (state_r == S_IDLE))
    else $error("result handed over but sequencer did not return to idle");

  a_scan_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && mem_we) |-> ev_vld_r)
    else $error("allocation wrote a word that was never read");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_idx_r <= words_r))
    else $error("scan ran past the words covered by the frame count");

  a_ack_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    res_ack |-> (state_r == S_DONE))
    else $error("result taken before it was finished");

endmodule

`default_nettype wire

/* rtl/frame_bitmap_allocator.sv */
// Frame bitmap allocator top level: channels, frame count register and result register.
//
// Commands arrive on in_ch: allocate the lowest free frame, free a frame by number, or mark
// or test the frame that holds a byte address. Each command gives exactly one transfer on
// out_ch. The frame count is written through cfg_ch, which is always ready; write it only
// while no command is in flight.
// After reset the bitmap is cleared by a sweep of one word per cycle over (MAX_FRAMES+31)/32
// words (1024 with the defaults); in_ch.ready stays low until the sweep ends.
// Free and mark read the word and write it back modified; test only reads it. Allocation
// reads one bitmap word per cycle through the shared word unit: out_ch.valid rises once the
// scan meets a word with a free frame below the frame count, or once every word below the
// frame count (capped at MAX_FRAMES) is read and no frame is free. A rejected allocation
// (page already mapped, zero count) skips the scan.
// Only one command is in the sequencer at a time. in_ch.ready rises as the result moves
// to the output register, so a new command is not taken before the last one has left the
// sequencer. The next command is accepted while a result waits in the output register.
// If the receiver stalls, the following result is held inside and in_ch.ready stays low
// until the output register is taken.
`default_nettype none

module frame_bitmap_allocator #(
  parameter int MAX_FRAMES = fba_pkg::MAX_FRAMES_DEF,
  parameter int PAGE_BYTES = fba_pkg::PAGE_BYTES_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  fba_in_if.sink    in_ch,
  fba_out_if.source out_ch,
  fba_cfg_if.sink   cfg_ch
);

  logic [15:0]      frame_count_r;
  logic             out_valid_r;
  fba_pkg::result_t out_res_r;

  logic             ctrl_idle;
  logic             ctrl_done;
  logic             res_ack;
  fba_pkg::result_t ctrl_res;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ctrl_idle;
  assign res_ack      = ctrl_done && (!out_valid_r || out_ch.ready);

  fba_ctrl #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .frame_count  (frame_count_r),
    .start        (in_ch.valid && ctrl_idle),
    .cmd          (in_ch.cmd),
    .address      (in_ch.address),
    .page_frame   (in_ch.page_frame),
    .kernel_alloc (in_ch.kernel_alloc),
    .rw_alloc     (in_ch.rw_alloc),
    .res_ack      (res_ack),
    .idle         (ctrl_idle),
    .done         (ctrl_done),
    .res          (ctrl_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_count_r <= fba_pkg::FRAME_COUNT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        frame_count_r <= cfg_ch.frame_count;
      end
      if (res_ack) begin
        out_valid_r <= 1'b1;
        out_res_r   <= ctrl_res;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_res_r.status;
  assign out_ch.frame_out = out_res_r.frame_out;
  assign out_ch.present   = out_res_r.present;
  assign out_ch.rw        = out_res_r.rw;
  assign out_ch.user      = out_res_r.user;
  assign out_ch.bit_set   = out_res_r.bit_set;

endmodule

`default_nettype wire

/* tb/sv/frame_bitmap_allocator_tb.sv */
// Self-checking testbench for the frame bitmap allocator: directed and random commands.
module frame_bitmap_allocator_tb;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 11;
  localparam int MAX_FRAMES      = fba_pkg::MAX_FRAMES_DEF;
  localparam int PAGE_BYTES      = fba_pkg::PAGE_BYTES_DEF;
  localparam int PAGE_SHIFT      = $clog2(PAGE_BYTES);
  localparam int MAX_GAP         = 11;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int ITEMS_PER_PHASE = 47;
  localparam int SETTLE_CYCLES   = 40;
  localparam int TIMEOUT_CYCLES  = 3000000;
  localparam int NUM_PHASES      = 12;

  // Tracks which frames are in use and the results the block owes us.
  class frame_map_checker;
    bit                   used_frames [MAX_FRAMES];
    int unsigned          frame_limit;
    fba_pkg::result_t     due_results [$];
    int                   mismatches;

    function new();
      frame_limit = fba_pkg::FRAME_COUNT_RST;
      mismatches  = 0;
    endfunction

    function void set_frame_count(logic [15:0] value);
      frame_limit = (value > MAX_FRAMES) ? MAX_FRAMES : value;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function void apply_command(fba_pkg::cmd_t op, logic [31:0] addr, logic [14:0] pf,
                                logic kern, logic wr);
      fba_pkg::result_t res;
      int unsigned      f;
      res = '0;
      case (op)
        fba_pkg::CMD_ALLOC: begin
          if (pf != 0) begin
            res.status = fba_pkg::STAT_NONE;
          end else begin
            f = 0;
            while (f < frame_limit && used_frames[f]) f++;
            if (f >= frame_limit) begin
              res.status = fba_pkg::STAT_FULL;
            end else begin
              used_frames[f] = 1'b1;
              res.frame_out  = f[14:0];
              res.present    = 1'b1;
              res.rw         = wr;
              res.user       = ~kern;
            end
          end
        end
        fba_pkg::CMD_FREE: begin
          if (pf == 0) begin
            res.status = fba_pkg::STAT_NONE;
          end else if (pf >= frame_limit) begin
            res.status = fba_pkg::STAT_RANGE;
          end else begin
            used_frames[pf] = 1'b0;
          end
        end
        default: begin
          f = addr >> PAGE_SHIFT;
          if (f >= frame_limit) begin
            res.status = fba_pkg::STAT_RANGE;
          end else if (op == fba_pkg::CMD_MARK) begin
            used_frames[f] = 1'b1;
          end else begin
            res.bit_set = used_frames[f];
          end
        end
      endcase
      due_results.push_back(res);
    endfunction

    task flag_mismatch(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    function string field_diff(string name, logic [14:0] want, logic [14:0] got);
      if (got !== want) return $sformatf(" %s expected %0h got %0h", name, want, got);
      return "";
    endfunction

    task check_result(fba_pkg::result_t got);
      fba_pkg::result_t want;
      string            diffs;
      if (due_results.size() == 0) begin
        flag_mismatch($sformatf("unexpected result, status %0h frame %0h",
                                got.status, got.frame_out));
        return;
      end
      want  = due_results.pop_front();
      diffs = {field_diff("status", 15'(want.status), 15'(got.status)),
               field_diff("frame_out", want.frame_out, got.frame_out),
               field_diff("present", 15'(want.present), 15'(got.present)),
               field_diff("rw", 15'(want.rw), 15'(got.rw)),
               field_diff("user", 15'(want.user), 15'(got.user)),
               field_diff("bit_set", 15'(want.bit_set), 15'(got.bit_set))};
      if (diffs != "") flag_mismatch(diffs);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  fba_in_if  in_ch ();
  fba_out_if out_ch ();
  fba_cfg_if cfg_ch ();

  frame_map_checker frame_book;
  bit               sender_eager;
  bit               sink_eager;

  frame_bitmap_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int draw_gap(bit eager);
    return eager ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // Mostly frames near the bottom, where allocations land, otherwise anywhere up to just past the limit.
  function automatic int unsigned pick_frame(int unsigned span);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return $urandom_range(0, ((span < 64) ? span : 64) + 2);
    return $urandom_range(0, span + 2);
  endfunction

  task automatic send_command(fba_pkg::cmd_t op, logic [31:0] addr, logic [14:0] pf,
                              logic kern, logic wr);
    int gap;
    gap = draw_gap(sender_eager);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.cmd          <= op;
    in_ch.address      <= addr;
    in_ch.page_frame   <= pf;
    in_ch.kernel_alloc <= kern;
    in_ch.rw_alloc     <= wr;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    frame_book.apply_command(op, addr, pf, kern, wr);
  endtask

  // Stop offering and let every outstanding result come back.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    while (frame_book.pending() != 0) @(posedge clk);
  endtask

  task automatic write_frame_count(logic [15:0] value);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.frame_count <= value;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
    frame_book.set_frame_count(value);
  endtask

  task automatic send_random_mix(int items, int unsigned span);
    int unsigned   roll;
    int unsigned   f;
    int unsigned   alloc_pct;
    logic [31:0]   addr;
    logic [14:0]   pf;
    fba_pkg::cmd_t op;
    // Small frame counts lean on allocation so the bitmap actually fills up.
    alloc_pct = (span <= 64) ? 50 : 35;
    repeat (items) begin
      addr = $urandom;
      pf   = 15'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < alloc_pct) begin
        op = fba_pkg::CMD_ALLOC;
        if ($urandom_range(0, 9) != 0) pf = '0;
      end else begin
        roll = $urandom_range(0, 99);
        op   = (roll < 40) ? fba_pkg::CMD_FREE :
               ((roll < 65) ? fba_pkg::CMD_MARK : fba_pkg::CMD_TEST);
        if ($urandom_range(0, 9) != 0) begin
          f = pick_frame(span);
          if (op == fba_pkg::CMD_FREE) pf = f[14:0];
          else addr = (f << PAGE_SHIFT) | $urandom_range(0, PAGE_BYTES - 1);
        end
      end
      send_command(op, addr, pf, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic run_phase(logic [15:0] count, int items);
    wait_for_drain();
    write_frame_count(count);
    sender_eager = ($urandom_range(0, 2) == 0);
    send_random_mix(items, (count > MAX_FRAMES) ? MAX_FRAMES : count);
  endtask

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, plus two long hold-offs that back the block up.
  initial begin : result_sink
    fba_pkg::result_t got;
    int unsigned      taken;
    int               gap;
    taken = 0;
    forever begin
      if (taken % 32 == 0) sink_eager = ($urandom_range(0, 3) == 0);
      if (taken == 60 || taken == 300) gap = HOLD_OFF_CYCLES;
      else gap = draw_gap(sink_eager);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.status    = fba_pkg::status_t'(out_ch.status);
      got.frame_out = out_ch.frame_out;
      got.present   = out_ch.present;
      got.rw        = out_ch.rw;
      got.user      = out_ch.user;
      got.bit_set   = out_ch.bit_set;
      frame_book.check_result(got);
      taken++;
    end
  end

  initial begin : stimulus
    logic [15:0] phase_counts [NUM_PHASES];
    frame_book = new();
    phase_counts = '{16'd1, 16'd33, 16'd32, 16'd31, 16'd65535, 16'd45,
                     16'd64, 16'd100, 16'd32767, 16'd70, 16'd37, 16'd32768};
    sender_eager = 1'b0;
    rst_n                <= 1'b0;
    in_ch.valid          <= 1'b0;
    in_ch.cmd            <= fba_pkg::CMD_ALLOC;
    in_ch.address        <= '0;
    in_ch.page_frame     <= '0;
    in_ch.kernel_alloc   <= 1'b0;
    in_ch.rw_alloc       <= 1'b0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.frame_count   <= fba_pkg::FRAME_COUNT_RST;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset frame count: frame zero handed out, mapped pages, edges of the address range.
    send_command(fba_pkg::CMD_ALLOC, 32'h0, 15'd0, 1'b0, 1'b1);
    send_command(fba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 15'd0, 1'b1, 1'b0);
    send_command(fba_pkg::CMD_ALLOC, 32'h0, 15'h7FFF, 1'b0, 1'b1);
    send_command(fba_pkg::CMD_ALLOC, 32'h0, 15'd1, 1'b1, 1'b1);
    send_command(fba_pkg::CMD_FREE, 32'h0, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_FREE, 32'h0, 15'h7FFF, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_MARK, 32'hFFFF_FFFF, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_TEST, 32'hFFFF_FFFF, 15'h7FFF, 1'b1, 1'b1);
    send_command(fba_pkg::CMD_MARK, 32'h07FF_FFFF, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_TEST, 32'h07FF_F000, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_TEST, 32'h0800_0000, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_FREE, 32'h0, 15'd1, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_TEST, 32'h0000_1FFF, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_ALLOC, 32'h0, 15'd0, 1'b1, 1'b1);
    send_command(fba_pkg::CMD_MARK, 32'h0000_2000, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_ALLOC, 32'h0, 15'd0, 1'b0, 1'b0);

    // With no frames managed nothing can be allocated and every frame is out of range.
    wait_for_drain();
    write_frame_count(16'd0);
    send_command(fba_pkg::CMD_ALLOC, 32'h0, 15'd0, 1'b0, 1'b1);
    send_command(fba_pkg::CMD_FREE, 32'h0, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_FREE, 32'h0, 15'd5, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_MARK, 32'h0, 15'd0, 1'b0, 1'b0);
    send_command(fba_pkg::CMD_TEST, 32'h0, 15'd0, 1'b0, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      run_phase(phase_counts[p], ITEMS_PER_PHASE);
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (frame_book.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/fba_pkg.sv
rtl/fba_in_if.sv
rtl/fba_out_if.sv
rtl/fba_cfg_if.sv
rtl/fba_bitmap_mem.sv
rtl/fba_word_unit.sv
rtl/fba_ctrl.sv
rtl/frame_bitmap_allocator.sv
tb/sv/frame_bitmap_allocator_tb.sv
